### rtl/core/bgr_pkg.sv
// shared types, constants and shade lookup for the background tile pixel renderer
// no dependencies
`default_nettype none

package bgr_pkg;

    localparam int VRAM_BYTES          = 8192;
    localparam int VRAM_AW             = 13;
    localparam int BANK_DEPTH          = VRAM_BYTES / 2;
    localparam int BANK_AW             = $clog2(BANK_DEPTH);
    localparam int LINE_TICKS_DEF      = 1232;
    localparam int FRAME_LAST_TICK_DEF = 280986;
    localparam int VBLANK_TICK         = 197120;
    localparam int VISIBLE_COLUMNS     = 160;
    localparam int VISIBLE_LINES       = 144;
    localparam int MAP_BASE            = 'h1800;
    localparam int RSP_DEPTH           = 4;

    localparam logic [7:0] SHADE_0 = 8'hFF;
    localparam logic [7:0] SHADE_1 = 8'hBD;
    localparam logic [7:0] SHADE_2 = 8'h7E;
    localparam logic [7:0] SHADE_3 = 8'h00;

    typedef enum logic {
        MODE_TICK  = 1'b0,
        MODE_WRITE = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [VRAM_AW-1:0] vram_address;
        logic [7:0]         vram_data;
    } req_t;

    typedef struct packed {
        logic       pixel_valid;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [7:0] shade;
        logic [7:0] line_number;
        logic       vblank_irq;
        logic       frame_done;
    } rsp_t;

    function automatic logic [7:0] gray_shade(input logic [1:0] color);
        logic [7:0] level;
        unique case (color)
            2'd0:    level = SHADE_0;
            2'd1:    level = SHADE_1;
            2'd2:    level = SHADE_2;
            default: level = SHADE_3;
        endcase
        return level;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bgr_ram.sv
// generic synchronous ram: one write port, two registered read ports
// no dependencies
`default_nettype none

module bgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr_a,
    output logic      [WIDTH-1:0] rdata_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // read-first: a read and a write at the same edge return the old byte
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

`default_nettype wire

### rtl/core/bgr_rsp_fifo.sv
// small result queue between the render pipeline and the result port
// depends on bgr_pkg
`default_nettype none

module bgr_rsp_fifo #(
    parameter int DEPTH = bgr_pkg::RSP_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire bgr_pkg::rsp_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output bgr_pkg::rsp_t      pop_data,
    output logic [CNT_W-1:0]   count
);

    bgr_pkg::rsp_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign pop = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

### rtl/core/background_tile_pixel_renderer.sv
// background tile pixel renderer: display timing, map and tile fetch, shade lookup
// a tick request passes the stage 1 and stage 2 registers, then the result queue, to m_valid
// throughput: one request per cycle while s_ready is high, into the 3-stage read pipeline
// reset: synchronous, active low; clears the tick counter, then s_ready stays low
// while all 4096 word pairs of both vram banks are swept to zero, one word pair per cycle
// depends on bgr_pkg, bgr_ram, bgr_rsp_fifo
`default_nettype none

module background_tile_pixel_renderer #(
    parameter int LINE_TICKS      = bgr_pkg::LINE_TICKS_DEF,
    parameter int FRAME_LAST_TICK = bgr_pkg::FRAME_LAST_TICK_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire bgr_pkg::req_t s_req,
    output logic               m_valid,
    input  wire logic          m_ready,
    output bgr_pkg::rsp_t      m_rsp
);

    localparam int TICK_W     = $clog2(FRAME_LAST_TICK + 1);
    localparam int CNT_W      = $clog2(FRAME_LAST_TICK + 2);
    localparam int COL_W      = $clog2(LINE_TICKS);
    localparam int LINE_RAW_W = $clog2((FRAME_LAST_TICK + 1) / LINE_TICKS + 1);
    localparam int LINE_W     = (LINE_RAW_W > 8) ? LINE_RAW_W : 8;
    localparam int BANK_AW    = bgr_pkg::BANK_AW;
    localparam int Q_DEPTH    = bgr_pkg::RSP_DEPTH;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic               clr_active_reg, clr_active_next;
    logic [BANK_AW-1:0] clr_idx_reg, clr_idx_next;

    logic               st1_valid_reg, st2_valid_reg;
    bgr_pkg::rsp_t      st1_reg, st2_reg, st0_rsp, push_rsp;

    logic               accept, tick_acc, wr_acc;
    logic [CNT_W-1:0]   count;
    logic               wrap, col_last, visible;
    logic [COL_W-1:0]   col_inc;
    logic [LINE_W-1:0]  line_inc;
    logic [BANK_AW-1:0] map_idx, tile_idx, wr_idx;
    logic [7:0]         wr_byte, map_byte;
    logic               we_even, we_odd;
    logic [7:0]         even_map, odd_map, even_tile, odd_tile;
    logic [2:0]         bit_sel;
    logic [1:0]         color;
    logic [Q_CNT_W-1:0] q_count, in_flight;

    // credit check keeps every request in flight a slot in the result queue
    assign in_flight = q_count + Q_CNT_W'(st1_valid_reg) + Q_CNT_W'(st2_valid_reg);
    assign s_ready   = !clr_active_reg && (in_flight < Q_CNT_W'(Q_DEPTH));
    assign accept    = s_valid && s_ready;
    assign tick_acc  = accept && (s_req.mode == bgr_pkg::MODE_TICK);
    assign wr_acc    = accept && (s_req.mode == bgr_pkg::MODE_WRITE);

    // stage 0: timing counters and map fetch
    always_comb begin
        count    = CNT_W'(tick_reg) + CNT_W'(1);
        wrap     = count > CNT_W'(FRAME_LAST_TICK);
        col_last = (col_reg == COL_W'(LINE_TICKS - 1));
        col_inc  = col_last ? '0 : col_reg + COL_W'(1);
        line_inc = col_last ? line_reg + LINE_W'(1) : line_reg;
        visible  = (col_inc < COL_W'(bgr_pkg::VISIBLE_COLUMNS))
                && (line_inc < LINE_W'(bgr_pkg::VISIBLE_LINES));
        map_idx  = BANK_AW'(bgr_pkg::MAP_BASE / 2)
                 + BANK_AW'({line_inc[7:3], col_inc[7:4]});

        st0_rsp.pixel_valid = visible;
        st0_rsp.pixel_x     = visible ? col_inc[7:0] : 8'd0;
        st0_rsp.pixel_y     = visible ? line_inc[7:0] : 8'd0;
        st0_rsp.shade       = 8'd0;
        st0_rsp.line_number = line_inc[7:0];
        st0_rsp.vblank_irq  = (count == CNT_W'(bgr_pkg::VBLANK_TICK));
        st0_rsp.frame_done  = wrap;

        tick_next = tick_reg;
        col_next  = col_reg;
        line_next = line_reg;
        if (tick_acc) begin
            tick_next = wrap ? '0 : TICK_W'(count);
            col_next  = wrap ? '0 : col_inc;
            line_next = wrap ? '0 : line_inc;
        end

        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg) begin
            clr_idx_next = clr_idx_reg + BANK_AW'(1);
            if (clr_idx_reg == '1) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg       <= '0;
            col_reg        <= '0;
            line_reg       <= '0;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            st1_valid_reg  <= 1'b0;
            st2_valid_reg  <= 1'b0;
        end else begin
            tick_reg       <= tick_next;
            col_reg        <= col_next;
            line_reg       <= line_next;
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
            st1_valid_reg  <= tick_acc;
            st2_valid_reg  <= st1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        st1_reg <= st0_rsp;
        st2_reg <= st1_reg;
    end

    // byte writes and the clearing sweep share the bank write ports
    assign wr_idx  = clr_active_reg ? clr_idx_reg : s_req.vram_address[12:1];
    assign wr_byte = clr_active_reg ? 8'd0 : s_req.vram_data;
    assign we_even = clr_active_reg || (wr_acc && !s_req.vram_address[0]);
    assign we_odd  = clr_active_reg || (wr_acc && s_req.vram_address[0]);

    // stage 1: tile row fetch, low plane from the even bank, high plane from the odd bank
    assign map_byte = st1_reg.pixel_x[3] ? odd_map : even_map;
    assign tile_idx = BANK_AW'({map_byte, st1_reg.pixel_y[2:0]});

    bgr_ram #(
        .WIDTH (8),
        .DEPTH (bgr_pkg::BANK_DEPTH)
    ) u_even_bank (
        .aclk    (aclk),
        .we      (we_even),
        .waddr   (wr_idx),
        .wdata   (wr_byte),
        .re      (1'b1),
        .raddr_a (map_idx),
        .rdata_a (even_map),
        .raddr_b (tile_idx),
        .rdata_b (even_tile)
    );

    bgr_ram #(
        .WIDTH (8),
        .DEPTH (bgr_pkg::BANK_DEPTH)
    ) u_odd_bank (
        .aclk    (aclk),
        .we      (we_odd),
        .waddr   (wr_idx),
        .wdata   (wr_byte),
        .re      (1'b1),
        .raddr_a (map_idx),
        .rdata_a (odd_map),
        .raddr_b (tile_idx),
        .rdata_b (odd_tile)
    );

    // stage 2: pixel decode and shade
    always_comb begin
        bit_sel  = ~st2_reg.pixel_x[2:0];
        color    = {odd_tile[bit_sel], even_tile[bit_sel]};
        push_rsp = st2_reg;
        push_rsp.shade = st2_reg.pixel_valid ? bgr_pkg::gray_shade(color) : 8'd0;
    end

    bgr_rsp_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_rsp_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (st2_valid_reg),
        .push_data (push_rsp),
        .pop_valid (m_valid),
        .pop_ready (m_ready),
        .pop_data  (m_rsp),
        .count     (q_count)
    );

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_flight <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overcommitted");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |=> !st1_valid_reg)
        else $error("tick entered pipeline during memory clear");

    a_counter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_reg <= TICK_W'(FRAME_LAST_TICK)) && (col_reg < COL_W'(LINE_TICKS)))
        else $error("timing counter out of range");

    a_wrap_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_acc && wrap) |=> (tick_reg == '0) && (col_reg == '0) && (line_reg == '0))
        else $error("frame wrap did not clear counters");

    a_pixel_in_area: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.pixel_valid) |->
            (m_rsp.pixel_x < 8'(bgr_pkg::VISIBLE_COLUMNS))
            && (m_rsp.pixel_y < 8'(bgr_pkg::VISIBLE_LINES)))
        else $error("pixel outside visible area");

    a_pulses_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_rsp.vblank_irq && m_rsp.frame_done))
        else $error("vblank and frame done on one result");

endmodule

`default_nettype wire
